### rtl/core/mgc_pkg.sv
// ----------------------------------------------------------------------------
// mgc_pkg
// Shared types, event codes, slot ordering and helpers for the pointer
// gesture classifier.
// ----------------------------------------------------------------------------
package mgc_pkg;

    localparam int CODE_W = 5;

    // event codes as seen on the result channel
    localparam logic [CODE_W-1:0] EV_MOVE       = 5'd0;
    localparam logic [CODE_W-1:0] EV_L_DOWN     = 5'd1;
    localparam logic [CODE_W-1:0] EV_M_DOWN     = 5'd2;
    localparam logic [CODE_W-1:0] EV_R_DOWN     = 5'd3;
    localparam logic [CODE_W-1:0] EV_L_CLICK    = 5'd4;
    localparam logic [CODE_W-1:0] EV_M_CLICK    = 5'd5;
    localparam logic [CODE_W-1:0] EV_R_CLICK    = 5'd6;
    localparam logic [CODE_W-1:0] EV_L_UP       = 5'd7;
    localparam logic [CODE_W-1:0] EV_M_UP       = 5'd8;
    localparam logic [CODE_W-1:0] EV_R_UP       = 5'd9;
    localparam logic [CODE_W-1:0] EV_L_DRAG     = 5'd10;
    localparam logic [CODE_W-1:0] EV_L_REPEAT   = 5'd11;
    localparam logic [CODE_W-1:0] EV_R_DRAG     = 5'd12;
    localparam logic [CODE_W-1:0] EV_L_DBL      = 5'd13;
    localparam logic [CODE_W-1:0] EV_M_DBL      = 5'd14;
    localparam logic [CODE_W-1:0] EV_R_DBL      = 5'd15;
    localparam logic [CODE_W-1:0] EV_WHEEL_UP   = 5'd16;
    localparam logic [CODE_W-1:0] EV_WHEEL_DOWN = 5'd17;

    // one bit per event in emission order
    localparam int NUM_SLOTS = 18;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic [SLOT_W-1:0] SLOT_MOVE       = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_L_DOWN     = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_M_DOWN     = 5'd2;
    localparam logic [SLOT_W-1:0] SLOT_R_DOWN     = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_L_CLICK    = 5'd4;
    localparam logic [SLOT_W-1:0] SLOT_L_UP       = 5'd5;
    localparam logic [SLOT_W-1:0] SLOT_M_CLICK    = 5'd6;
    localparam logic [SLOT_W-1:0] SLOT_M_UP       = 5'd7;
    localparam logic [SLOT_W-1:0] SLOT_R_CLICK    = 5'd8;
    localparam logic [SLOT_W-1:0] SLOT_R_UP       = 5'd9;
    localparam logic [SLOT_W-1:0] SLOT_L_DRAG     = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_L_REPEAT   = 5'd11;
    localparam logic [SLOT_W-1:0] SLOT_R_DRAG     = 5'd12;
    localparam logic [SLOT_W-1:0] SLOT_L_DBL      = 5'd13;
    localparam logic [SLOT_W-1:0] SLOT_M_DBL      = 5'd14;
    localparam logic [SLOT_W-1:0] SLOT_R_DBL      = 5'd15;
    localparam logic [SLOT_W-1:0] SLOT_WHEEL_UP   = 5'd16;
    localparam logic [SLOT_W-1:0] SLOT_WHEEL_DOWN = 5'd17;

    typedef logic [NUM_SLOTS-1:0] event_mask_t;

    // queue between classifier and emitter
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // register map
    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_CLICK_MAX    = 2'd0;
    localparam logic [1:0] REG_CLICK_RADIUS = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd2;
    localparam logic [1:0] REG_DOUBLE_CLICK = 2'd3;

    localparam logic [15:0] RST_CLICK_MAX    = 16'd500;
    localparam logic [7:0]  RST_CLICK_RADIUS = 8'd4;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd1000;
    localparam logic [15:0] RST_DOUBLE_CLICK = 16'd500;

    typedef struct packed {
        logic [15:0] click_max_ms;
        logic [7:0]  click_radius;
        logic [15:0] long_press_ms;
        logic [15:0] double_click_ms;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        event_mask_t data;
    } fifo_out_t;

    function automatic logic [CODE_W-1:0] slot_code(input logic [SLOT_W-1:0] slot);
        logic [CODE_W-1:0] code;
        unique case (slot)
            SLOT_MOVE:       code = EV_MOVE;
            SLOT_L_DOWN:     code = EV_L_DOWN;
            SLOT_M_DOWN:     code = EV_M_DOWN;
            SLOT_R_DOWN:     code = EV_R_DOWN;
            SLOT_L_CLICK:    code = EV_L_CLICK;
            SLOT_L_UP:       code = EV_L_UP;
            SLOT_M_CLICK:    code = EV_M_CLICK;
            SLOT_M_UP:       code = EV_M_UP;
            SLOT_R_CLICK:    code = EV_R_CLICK;
            SLOT_R_UP:       code = EV_R_UP;
            SLOT_L_DRAG:     code = EV_L_DRAG;
            SLOT_L_REPEAT:   code = EV_L_REPEAT;
            SLOT_R_DRAG:     code = EV_R_DRAG;
            SLOT_L_DBL:      code = EV_L_DBL;
            SLOT_M_DBL:      code = EV_M_DBL;
            SLOT_R_DBL:      code = EV_R_DBL;
            SLOT_WHEEL_UP:   code = EV_WHEEL_UP;
            SLOT_WHEEL_DOWN: code = EV_WHEEL_DOWN;
            default:         code = EV_MOVE;
        endcase
        return code;
    endfunction

    // |a - b| <= r on 16-bit signed coordinates
    function automatic logic within_radius(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic [7:0] r);
        logic [16:0] d;
        logic [16:0] mag;
        d   = {a[15], a} - {b[15], b};
        mag = d[16] ? (17'd0 - d) : d;
        return mag <= {9'd0, r};
    endfunction

endpackage

### rtl/core/mgc_regs.sv
// ----------------------------------------------------------------------------
// mgc_regs
// APB-style configuration registers for the gesture classifier.
// ----------------------------------------------------------------------------
module mgc_regs
    import mgc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.click_max_ms    <= RST_CLICK_MAX;
            cfg_reg.click_radius    <= RST_CLICK_RADIUS;
            cfg_reg.long_press_ms   <= RST_LONG_PRESS;
            cfg_reg.double_click_ms <= RST_DOUBLE_CLICK;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CLICK_MAX:    cfg_reg.click_max_ms    <= pwdata[15:0];
                REG_CLICK_RADIUS: cfg_reg.click_radius    <= pwdata[7:0];
                REG_LONG_PRESS:   cfg_reg.long_press_ms   <= pwdata[15:0];
                REG_DOUBLE_CLICK: cfg_reg.double_click_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CLICK_MAX:    prdata = {16'd0, cfg_reg.click_max_ms};
            REG_CLICK_RADIUS: prdata = {24'd0, cfg_reg.click_radius};
            REG_LONG_PRESS:   prdata = {16'd0, cfg_reg.long_press_ms};
            REG_DOUBLE_CLICK: prdata = {16'd0, cfg_reg.double_click_ms};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/mgc_front.sv
// ----------------------------------------------------------------------------
// mgc_front
// Accepts ticks, keeps pointer and button history, and turns each tick into
// a mask of events in emission order.
// ----------------------------------------------------------------------------
module mgc_front
    import mgc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_time_now_ms,
    input  logic signed [15:0] s_pointer_x,
    input  logic signed [15:0] s_pointer_y,
    input  logic               s_left_down,
    input  logic               s_middle_down,
    input  logic               s_right_down,
    input  logic               s_wheel_up,
    input  logic               s_wheel_down,
    input  logic               s_in_client,
    input  logic               fifo_full,
    output logic               push,
    output event_mask_t        push_data
);

    logic signed [15:0] last_x_reg, last_y_reg;
    logic signed [15:0] lpress_x_reg, lpress_y_reg;
    logic signed [15:0] rpress_x_reg, rpress_y_reg;
    logic [2:0]  buttons_reg;
    logic [1:0]  wheel_held_reg;
    logic [31:0] press_time_reg [3];
    logic [31:0] click_time_reg [3];

    logic        accept;
    logic        active;
    logic [2:0]  btn;
    logic [1:0]  wheel_all;
    logic        moved;
    logic [2:0]  down_edge, up_edge, ok_time, ok_click, clicked, dbl;
    logic [31:0] elapsed [3];
    logic        held_l, long_l;
    event_mask_t mask;

    assign s_ready   = !fifo_full;
    assign accept    = s_valid && s_ready;
    assign active    = accept && s_in_client;
    assign btn       = {s_right_down, s_middle_down, s_left_down};
    assign wheel_all = wheel_held_reg | {s_wheel_down, s_wheel_up};
    assign moved     = (s_pointer_x != last_x_reg) || (s_pointer_y != last_y_reg);
    assign down_edge = ~buttons_reg & btn;
    assign up_edge   = buttons_reg & ~btn;

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            elapsed[b] = s_time_now_ms - press_time_reg[b];
            ok_time[b] = elapsed[b] < {16'd0, cfg.click_max_ms};
            dbl[b]     = s_time_now_ms < (click_time_reg[b] + {16'd0, cfg.double_click_ms});
        end
        // middle button has no travel limit
        ok_click[0] = ok_time[0]
                    && within_radius(lpress_x_reg, s_pointer_x, cfg.click_radius)
                    && within_radius(lpress_y_reg, s_pointer_y, cfg.click_radius);
        ok_click[1] = ok_time[1];
        ok_click[2] = ok_time[2]
                    && within_radius(rpress_x_reg, s_pointer_x, cfg.click_radius)
                    && within_radius(rpress_y_reg, s_pointer_y, cfg.click_radius);
    end

    assign clicked = up_edge & ok_click;
    assign held_l  = buttons_reg[0] && btn[0];
    assign long_l  = elapsed[0] > {16'd0, cfg.long_press_ms};

    always_comb begin
        mask                  = '0;
        mask[SLOT_MOVE]       = moved;
        mask[SLOT_L_DOWN]     = down_edge[0];
        mask[SLOT_M_DOWN]     = down_edge[1];
        mask[SLOT_R_DOWN]     = down_edge[2];
        mask[SLOT_L_CLICK]    = clicked[0];
        mask[SLOT_L_UP]       = up_edge[0];
        mask[SLOT_M_CLICK]    = clicked[1];
        mask[SLOT_M_UP]       = up_edge[1];
        mask[SLOT_R_CLICK]    = clicked[2];
        mask[SLOT_R_UP]       = up_edge[2];
        mask[SLOT_L_DRAG]     = held_l && moved;
        mask[SLOT_L_REPEAT]   = held_l && long_l;
        mask[SLOT_R_DRAG]     = buttons_reg[2] && btn[2] && moved;
        mask[SLOT_L_DBL]      = clicked[0] && dbl[0];
        mask[SLOT_M_DBL]      = clicked[1] && dbl[1];
        mask[SLOT_R_DBL]      = clicked[2] && dbl[2];
        mask[SLOT_WHEEL_UP]   = wheel_all[0];
        mask[SLOT_WHEEL_DOWN] = wheel_all[1];
    end

    // empty ticks produce nothing downstream
    assign push      = active && (mask != '0);
    assign push_data = mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            lpress_x_reg   <= '0;
            lpress_y_reg   <= '0;
            rpress_x_reg   <= '0;
            rpress_y_reg   <= '0;
            buttons_reg    <= '0;
            wheel_held_reg <= '0;
            for (int b = 0; b < 3; b++) begin
                press_time_reg[b] <= '0;
                click_time_reg[b] <= '0;
            end
        end else if (accept) begin
            if (!s_in_client) begin
                // outside the window: only accumulate wheel notches
                wheel_held_reg <= wheel_all;
            end else begin
                wheel_held_reg <= '0;
                last_x_reg     <= s_pointer_x;
                last_y_reg     <= s_pointer_y;
                buttons_reg    <= btn;
                for (int b = 0; b < 3; b++) begin
                    if (down_edge[b]) press_time_reg[b] <= s_time_now_ms;
                    if (clicked[b])   click_time_reg[b] <= s_time_now_ms;
                end
                if (down_edge[0]) begin
                    lpress_x_reg <= s_pointer_x;
                    lpress_y_reg <= s_pointer_y;
                end
                if (down_edge[2]) begin
                    rpress_x_reg <= s_pointer_x;
                    rpress_y_reg <= s_pointer_y;
                end
            end
        end
    end

    // a tick outside the window must never reach the emitter
    a_no_push_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_in_client) |-> !push)
        else $error("push on a tick outside the window");

    // wheel notches held outside are flushed by the next tick inside
    a_wheel_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        active |=> (wheel_held_reg == 2'b00))
        else $error("held wheel notches not cleared");

    // a left or right click implies a release of the same button
    a_click_needs_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((!push_data[SLOT_L_CLICK] || push_data[SLOT_L_UP])
              && (!push_data[SLOT_R_CLICK] || push_data[SLOT_R_UP])))
        else $error("click without release");

endmodule

### rtl/core/mgc_fifo.sv
// ----------------------------------------------------------------------------
// mgc_fifo
// Short queue of event masks between classifier and emitter.
// ----------------------------------------------------------------------------
module mgc_fifo
    import mgc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  event_mask_t push_data,
    input  logic        pop,
    output logic        full,
    output fifo_out_t   head
);

    event_mask_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/mgc_back.sv
// ----------------------------------------------------------------------------
// mgc_back
// Emitter: walks each event mask in slot order, one event per cycle while not
// stalled by m_ready, into the result output register.
// ----------------------------------------------------------------------------
module mgc_back
    import mgc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  fifo_out_t         head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_event_code,
    output logic              m_last_event
);

    event_mask_t       cur_reg, cur_next;
    event_mask_t       rest;
    logic              valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              last_reg;
    logic              out_free;
    logic              emit;
    logic [SLOT_W-1:0] low_slot;

    assign out_free = !valid_reg || m_ready;
    assign emit     = out_free && (cur_reg != '0);
    assign rest     = emit ? (cur_reg & (cur_reg - 1'b1)) : cur_reg;
    assign pop      = head.valid && (rest == '0);
    assign cur_next = pop ? head.data : rest;

    always_comb begin
        low_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (cur_reg[i]) low_slot = SLOT_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            cur_reg <= cur_next;
            if (out_free) valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            code_reg <= slot_code(low_slot);
            last_reg <= (rest == '0);
        end
    end

    assign m_valid      = valid_reg;
    assign m_event_code = code_reg;
    assign m_last_event = last_reg;

    // every word taken from the queue carries at least one event
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (head.data != '0))
        else $error("empty event mask in queue");

    // a stalled result holds its code and marker
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |=> (valid_reg && $stable(code_reg) && $stable(last_reg)))
        else $error("result changed while stalled");

    // events left in the current mask mean the tick is not finished
    a_last_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> ((rest == '0) || (cur_reg[low_slot] && !(rest == '0))))
        else $error("last marker inconsistent with remaining events");

endmodule

### rtl/core/mouse_gesture_classifier.sv
// ----------------------------------------------------------------------------
// mouse_gesture_classifier
// Per-tick pointer event classifier: tick classifier, event-mask queue and
// one-event-per-cycle emitter unless stalled, with APB-style config registers.
// ----------------------------------------------------------------------------
// Path: a tick's mask passes the queue, current-mask and result registers.
// Throughput: one tick per cycle while the 4-entry mask queue has room; the
//   emitter drains one event per cycle while m_ready does not stall the single
//   result register, and a tick carries up to 12 events.
// Reset: aresetn synchronous active low; clears history, queue and output,
//   restores register defaults (500, 4, 1000, 500).
module mouse_gesture_classifier
    import mgc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_time_now_ms,
    input  logic signed [15:0] s_pointer_x,
    input  logic signed [15:0] s_pointer_y,
    input  logic               s_left_down,
    input  logic               s_middle_down,
    input  logic               s_right_down,
    input  logic               s_wheel_up,
    input  logic               s_wheel_down,
    input  logic               s_in_client,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CODE_W-1:0]  m_event_code,
    output logic               m_last_event
);

    cfg_t        cfg;
    logic        push, pop, fifo_full;
    event_mask_t push_data;
    fifo_out_t   head;

    mgc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mgc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_time_now_ms (s_time_now_ms),
        .s_pointer_x   (s_pointer_x),
        .s_pointer_y   (s_pointer_y),
        .s_left_down   (s_left_down),
        .s_middle_down (s_middle_down),
        .s_right_down  (s_right_down),
        .s_wheel_up    (s_wheel_up),
        .s_wheel_down  (s_wheel_down),
        .s_in_client   (s_in_client),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_data     (push_data)
    );

    mgc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (fifo_full),
        .head      (head)
    );

    mgc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_last_event (m_last_event)
    );

endmodule
